>>> sv/bce_pkg.sv
`default_nettype none

package bce_pkg;

  // batch capacity and derived widths
  localparam int unsigned BATCH_WORDS = 1024;
  localparam int unsigned CNT_W       = $clog2(BATCH_WORDS + 1);
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned MAX_WORDS   = 10;
  localparam int unsigned K_W         = $clog2(MAX_WORDS);

  // stream widths
  localparam int unsigned IN_DATA_W  = 288;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned OUT_USER_W = 4;
  localparam int unsigned WIN_W      = 49;

  // address window
  localparam logic [WIN_W-1:0] PAGE_BYTES   = 49'd4096;
  localparam logic [WIN_W-1:0] WINDOW_RESET = 49'd8388608;

  // command word constants
  localparam logic [31:0] HDR_COPY   = 32'h54F0_0008;
  localparam logic [31:0] HDR_FILL   = 32'h5430_0005;
  localparam logic [31:0] DEPTH32    = 32'h0300_0000;
  localparam logic [31:0] ROP_COPY   = 32'h00CC_0000;
  localparam logic [31:0] ROP_FILL   = 32'h00F0_0000;
  localparam logic [31:0] TERMINATOR = 32'h0500_0000;

  // words needed per request kind
  localparam logic [K_W-1:0] LEN_BLIT = 4'd10;
  localparam logic [K_W-1:0] LEN_FILL = 4'd7;
  localparam logic [K_W-1:0] LEN_ONE  = 4'd1;

  typedef enum logic [1:0] {
    CMD_BEGIN = 2'd0,
    CMD_BLIT  = 2'd1,
    CMD_FILL  = 2'd2,
    CMD_END   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_ROOM  = 3'd1,
    ST_RECT  = 3'd2,
    ST_PITCH = 3'd3,
    ST_ADDR  = 3'd4
  } status_e;

  // what the back end has to emit for one request
  typedef enum logic [1:0] {
    JOB_INFO = 2'd0,
    JOB_BLIT = 2'd1,
    JOB_FILL = 2'd2,
    JOB_END  = 2'd3
  } job_e;

  typedef struct packed {
    job_e              kind;
    status_e           status;
    logic [IDX_W-1:0]  base;
    logic [15:0]       dst_pitch_b;
    logic [15:0]       src_pitch_b;
    logic [63:0]       dst_addr;
    logic [63:0]       src_addr;
    logic [15:0]       src_x;
    logic [15:0]       src_y;
    logic [15:0]       dst_x;
    logic [15:0]       dst_y;
    logic [15:0]       width;
    logic [15:0]       height;
    logic [31:0]       color;
  } job_t;

endpackage

`default_nettype wire

>>> sv/bce_front.sv
`default_nettype none

module bce_front
  import bce_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_tvalid_i,
  output logic                      s_tready_o,
  input  wire logic [IN_DATA_W-1:0] s_tdata_i,
  input  wire logic [1:0]           s_tuser_i,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [WIN_W-1:0]     cfg_data_i,
  input  wire logic                 q_full_i,
  output logic                      push_o,
  output job_t                      job_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic             sealed_q, sealed_d;
  logic [WIN_W-1:0] lim_q;
  logic             win_small_q;

  logic [63:0] dst_addr, src_addr;
  logic [15:0] dst_px, src_px, sx, sy, dx, dy, w, h;
  logic [31:0] color;
  cmd_e        cmd;
  logic        accept;

  logic             bad_dpitch, bad_spitch, bad_drect, bad_srect, bad_daddr, bad_saddr;
  logic [K_W-1:0]   need;
  logic             no_room;
  logic [CNT_W:0]   room_sum;
  status_e          status;

  function automatic logic pitch_bad(input logic [15:0] px);
    pitch_bad = (px == 16'd0) || (px[15:14] != 2'd0);
  endfunction

  function automatic logic rect_bad(input logic [15:0] x, input logic [15:0] y,
                                    input logic [15:0] rw, input logic [15:0] rh);
    logic [16:0] ex, ey;
    ex = {1'b0, x} + {1'b0, rw};
    ey = {1'b0, y} + {1'b0, rh};
    rect_bad = (rw == 16'd0) || (rh == 16'd0) || (ex > 17'h10000) || (ey > 17'h10000);
  endfunction

  // unpack the request
  assign dst_addr = s_tdata_i[63:0];
  assign dst_px   = s_tdata_i[79:64];
  assign src_addr = s_tdata_i[143:80];
  assign src_px   = s_tdata_i[159:144];
  assign sx       = s_tdata_i[175:160];
  assign sy       = s_tdata_i[191:176];
  assign dx       = s_tdata_i[207:192];
  assign dy       = s_tdata_i[223:208];
  assign w        = s_tdata_i[239:224];
  assign h        = s_tdata_i[255:240];
  assign color    = s_tdata_i[287:256];
  assign cmd      = cmd_e'(s_tuser_i);

  assign s_tready_o  = !q_full_i;
  assign accept      = s_tvalid_i && s_tready_o;
  assign cfg_ready_o = 1'b1;

  // window register, kept as the highest page start it admits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q       <= WINDOW_RESET - PAGE_BYTES;
      win_small_q <= 1'b0;
    end else if (cfg_valid_i) begin
      lim_q       <= cfg_data_i - PAGE_BYTES;
      win_small_q <= cfg_data_i < PAGE_BYTES;
    end
  end

  // checks, all in parallel
  always_comb begin
    bad_dpitch = pitch_bad(dst_px);
    bad_spitch = pitch_bad(src_px);
    bad_drect  = rect_bad(dx, dy, w, h);
    bad_srect  = rect_bad(sx, sy, w, h);
    bad_daddr  = (dst_addr[11:0] != 12'd0) || (dst_addr[63:WIN_W] != '0) || win_small_q ||
                 (dst_addr[WIN_W-1:0] > lim_q);
    bad_saddr  = (src_addr[11:0] != 12'd0) || (src_addr[63:WIN_W] != '0) || win_small_q ||
                 (src_addr[WIN_W-1:0] > lim_q);
  end

  // room in the batch
  always_comb begin
    case (cmd)
      CMD_BLIT: need = LEN_BLIT;
      CMD_FILL: need = LEN_FILL;
      default:  need = LEN_ONE;
    endcase
    room_sum = {1'b0, count_q} + (CNT_W + 1)'(need);
    no_room  = sealed_q || (room_sum > (CNT_W + 1)'(BATCH_WORDS));
  end

  // first failing check, in a fixed order for each request kind
  always_comb begin
    status = ST_OK;
    case (cmd)
      CMD_BLIT: begin
        if (bad_dpitch || bad_spitch) status = ST_PITCH;
        else if (no_room)             status = ST_ROOM;
        else if (bad_drect || bad_srect) status = ST_RECT;
        else if (bad_daddr || bad_saddr) status = ST_ADDR;
      end
      CMD_FILL: begin
        if (no_room)         status = ST_ROOM;
        else if (bad_drect)  status = ST_RECT;
        else if (bad_dpitch) status = ST_PITCH;
        else if (bad_daddr)  status = ST_ADDR;
      end
      CMD_END: begin
        if (no_room) status = ST_ROOM;
      end
      default: status = ST_OK;
    endcase
  end

  // job for the back end
  always_comb begin
    job_o.status      = status;
    job_o.base        = IDX_W'(count_q);
    job_o.dst_pitch_b = {dst_px[13:0], 2'b00};
    job_o.src_pitch_b = {src_px[13:0], 2'b00};
    job_o.dst_addr    = dst_addr;
    job_o.src_addr    = src_addr;
    job_o.src_x       = sx;
    job_o.src_y       = sy;
    job_o.dst_x       = dx;
    job_o.dst_y       = dy;
    job_o.width       = w;
    job_o.height      = h;
    job_o.color       = color;
    if (status != ST_OK) begin
      job_o.kind = JOB_INFO;
    end else begin
      case (cmd)
        CMD_BLIT: job_o.kind = JOB_BLIT;
        CMD_FILL: job_o.kind = JOB_FILL;
        CMD_END:  job_o.kind = JOB_END;
        default:  job_o.kind = JOB_INFO;
      endcase
    end
  end

  assign push_o = accept;

  // batch state moves as soon as a request is taken
  always_comb begin
    count_d  = count_q;
    sealed_d = sealed_q;
    if (accept) begin
      if (cmd == CMD_BEGIN) begin
        count_d  = '0;
        sealed_d = 1'b0;
      end else if (status == ST_OK) begin
        count_d = room_sum[CNT_W-1:0];
        if (cmd == CMD_END) sealed_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      sealed_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      sealed_q <= sealed_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/bce_queue.sv
`default_nettype none

module bce_queue
  import bce_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t job_i,
  output logic      full_o,
  output logic      head_vld_o,
  output job_t      head_o,
  input  wire logic pop_i
);

  job_t head_q, head_d, tail_q, tail_d;
  logic head_vld_q, head_vld_d, tail_vld_q, tail_vld_d;

  // two-slot queue, the head slot always holds the oldest job
  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    head_vld_d = head_vld_q;
    tail_vld_d = tail_vld_q;
    if (pop_i) begin
      head_d     = tail_q;
      head_vld_d = tail_vld_q;
      tail_vld_d = 1'b0;
    end
    if (push_i) begin
      if (!head_vld_d) begin
        head_d     = job_i;
        head_vld_d = 1'b1;
      end else begin
        tail_d     = job_i;
        tail_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      tail_vld_q <= 1'b0;
    end else begin
      head_vld_q <= head_vld_d;
      tail_vld_q <= tail_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assign full_o     = tail_vld_q;
  assign head_vld_o = head_vld_q;
  assign head_o     = head_q;

endmodule

`default_nettype wire

>>> sv/bce_back.sv
`default_nettype none

module bce_back
  import bce_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  head_vld_i,
  input  wire job_t                  head_i,
  output logic                       pop_o,
  output logic                       m_tvalid_o,
  input  wire logic                  m_tready_i,
  output logic [OUT_DATA_W-1:0]      m_tdata_o,
  output logic [OUT_USER_W-1:0]      m_tuser_o,
  output logic                       m_tlast_o
);

  logic [K_W-1:0]   k_q, k_d;
  logic             out_vld_q, out_vld_d;
  logic [31:0]      word_q, word_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             wvld_q, wvld_d;
  status_e          status_q, status_d;
  logic             last_q, last_d;

  logic [K_W-1:0] len;
  logic           is_last, emit;

  // words in the current job
  always_comb begin
    case (head_i.kind)
      JOB_BLIT: len = LEN_BLIT;
      JOB_FILL: len = LEN_FILL;
      default:  len = LEN_ONE;
    endcase
    is_last = (k_q == len - LEN_ONE);
    emit    = head_vld_i && (!out_vld_q || m_tready_i);
    pop_o   = emit && is_last;
  end

  // word selection for the current step
  always_comb begin
    word_d   = 32'd0;
    idx_d    = head_i.base + IDX_W'(k_q);
    wvld_d   = 1'b1;
    status_d = ST_OK;
    last_d   = is_last;
    case (head_i.kind)
      JOB_BLIT: begin
        case (k_q)
          4'd0:    word_d = HDR_COPY;
          4'd1:    word_d = ROP_COPY | DEPTH32 | {16'd0, head_i.dst_pitch_b};
          4'd2:    word_d = {head_i.dst_y, head_i.dst_x};
          4'd3:    word_d = {head_i.height, head_i.width};
          4'd4:    word_d = head_i.dst_addr[31:0];
          4'd5:    word_d = head_i.dst_addr[63:32];
          4'd6:    word_d = {head_i.src_y, head_i.src_x};
          4'd7:    word_d = {16'd0, head_i.src_pitch_b};
          4'd8:    word_d = head_i.src_addr[31:0];
          4'd9:    word_d = head_i.src_addr[63:32];
          default: word_d = 32'd0;
        endcase
      end
      JOB_FILL: begin
        case (k_q)
          4'd0:    word_d = HDR_FILL;
          4'd1:    word_d = DEPTH32 | ROP_FILL | {16'd0, head_i.dst_pitch_b};
          4'd2:    word_d = head_i.dst_addr[31:0];
          4'd3:    word_d = head_i.dst_addr[63:32];
          4'd4:    word_d = head_i.color;
          4'd5:    word_d = {head_i.dst_y, head_i.dst_x};
          4'd6:    word_d = {head_i.height, head_i.width};
          default: word_d = 32'd0;
        endcase
      end
      JOB_END: word_d = TERMINATOR;
      default: begin
        idx_d    = '0;
        wvld_d   = 1'b0;
        status_d = head_i.status;
      end
    endcase
  end

  // step counter and output valid
  always_comb begin
    k_d       = k_q;
    out_vld_d = out_vld_q;
    if (emit) begin
      out_vld_d = 1'b1;
      k_d       = is_last ? '0 : k_q + LEN_ONE;
    end else if (m_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q       <= '0;
      out_vld_q <= 1'b0;
    end else begin
      k_q       <= k_d;
      out_vld_q <= out_vld_d;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      word_q   <= word_d;
      idx_q    <= idx_d;
      wvld_q   <= wvld_d;
      status_q <= status_d;
      last_q   <= last_d;
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = {(OUT_DATA_W - IDX_W - 32)'(0), idx_q, word_q};
  assign m_tuser_o  = {status_q, wvld_q};
  assign m_tlast_o  = last_q;

endmodule

`default_nettype wire

>>> sv/blit_command_encoder.sv
`default_nettype none

// Blitter command batch builder. Each request on the slave stream (begin, blit, fill,
// end, selected by tuser) is checked and answered on the master stream: a good blit
// gives ten batch words, a good fill seven, an end one terminator word, and a begin or
// a rejected request one status transfer with no word. Each request is taken by the front
// end into a two-slot queue while the queue has room; the back end then sends one transfer
// per cycle through its output register while the master side is ready, and a queued
// request follows the previous one with no gap. The window register may be written at
// any time the block is idle; it takes effect on the next request.
module blit_command_encoder
  import bce_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // dst_addr, dst_pitch_px, src_addr, src_pitch_px, src_x, src_y, dst_x, dst_y,
  // width, height, color
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // cmd
  input  wire logic [1:0]            s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // word, word_index, zero padding
  output logic [OUT_DATA_W-1:0]      m_tdata,
  // word_valid, status
  output logic [OUT_USER_W-1:0]      m_tuser,
  output logic                       m_tlast,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [WIN_W-1:0]      cfg_data
);

  logic q_full, push, head_vld, pop;
  job_t job, head;

  // request checks and batch state
  bce_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid),
    .s_tready_o  (s_tready),
    .s_tdata_i   (s_tdata),
    .s_tuser_i   (s_tuser),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (job)
  );

  // job queue between front and back
  bce_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .job_i      (job),
    .full_o     (q_full),
    .head_vld_o (head_vld),
    .head_o     (head),
    .pop_i      (pop)
  );

  // word sequencer
  bce_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_vld_i (head_vld),
    .head_i     (head),
    .pop_o      (pop),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata),
    .m_tuser_o  (m_tuser),
    .m_tlast_o  (m_tlast)
  );

`ifndef SYNTHESIS
  // a batch word always carries an ok status
  a_word_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && m_tuser[0]) |-> (m_tuser[3:1] == ST_OK))
    else $error("batch word with non-ok status");

  // a transfer without a word is always the only one of its request
  a_info_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && !m_tuser[0]) |-> m_tlast)
    else $error("status transfer without last");

  // words of one command follow at once with consecutive indices
  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && m_tready && m_tuser[0] && !m_tlast) |=>
      (m_tvalid && m_tuser[0] &&
       (m_tdata[IDX_W+31:32] == IDX_W'($past(m_tdata[IDX_W+31:32]) + 1'b1))))
    else $error("word index not consecutive within a command");

  // the queue never refuses while the front end pushes
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !push)
    else $error("push into a full queue");
`endif

endmodule

`default_nettype wire

>>> bench/tb_blit_command_encoder.sv
module tb_blit_command_encoder;
  import bce_pkg::*;

  // command word fields, rebuilt here from the encoding rules
  localparam logic [31:0] COPY_HEADER  = 32'h54F0_0008;
  localparam logic [31:0] FILL_HEADER  = 32'h5430_0005;
  localparam logic [31:0] COLOUR_DEPTH = 32'd3 << 24;
  localparam logic [31:0] ROP_SOURCE   = 32'hCC << 16;
  localparam logic [31:0] ROP_PATTERN  = 32'hF0 << 16;
  localparam logic [31:0] END_WORD     = 32'h0A << 23;
  localparam int unsigned CAPACITY     = 1024;
  localparam logic [WIN_W-1:0] WIN_MIN  = 49'd4096;
  localparam logic [WIN_W-1:0] WIN_MAX  = 49'h1_0000_0000_0000;
  localparam logic [WIN_W-1:0] WIN_BOOT = 49'd8388608;

  typedef struct {
    cmd_e        cmd;
    logic [63:0] dst_addr;
    logic [15:0] dst_pitch;
    logic [63:0] src_addr;
    logic [15:0] src_pitch;
    logic [15:0] src_x;
    logic [15:0] src_y;
    logic [15:0] dst_x;
    logic [15:0] dst_y;
    logic [15:0] rect_w;
    logic [15:0] rect_h;
    logic [31:0] color;
  } req_t;

  typedef struct {
    logic [31:0] word;
    logic [9:0]  index;
    logic        valid;
    status_e     status;
    logic        last;
  } reply_t;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  s_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic [1:0]            s_tuser   = '0;
  logic                  m_tready  = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [WIN_W-1:0]      cfg_data  = '0;
  wire                   s_tready;
  wire                   m_tvalid;
  wire [OUT_DATA_W-1:0]  m_tdata;
  wire [OUT_USER_W-1:0]  m_tuser;
  wire                   m_tlast;
  wire                   cfg_ready;

  // predictor state
  logic [WIN_W-1:0] window_q;
  logic [10:0]      words_used;
  logic             batch_sealed;
  reply_t           reply_q[$];

  int error_count  = 0;
  int tx_gap_max   = 18;
  int rx_stall_max = 18;
  int rx_hold_len  = 0;

  blit_command_encoder u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #6000000;
    $display("Test completed with failures");
    $finish;
  end

  // request packing, first field in the low bits
  function automatic logic [IN_DATA_W-1:0] pack_req(input req_t r);
    return {r.color, r.rect_h, r.rect_w, r.dst_y, r.dst_x, r.src_y, r.src_x,
            r.src_pitch, r.src_addr, r.dst_pitch, r.dst_addr};
  endfunction

  // checks on request fields
  function automatic bit pitch_good(input logic [15:0] px);
    logic [17:0] bytes;
    bytes = {px, 2'b00};
    return (bytes != 18'd0) && (bytes <= 18'hFFFF);
  endfunction

  function automatic bit rect_good(input logic [15:0] x, input logic [15:0] y,
                                   input logic [15:0] w, input logic [15:0] h);
    return (w != 16'd0) && (h != 16'd0) &&
           ({1'b0, x} + {1'b0, w} <= 17'h10000) &&
           ({1'b0, y} + {1'b0, h} <= 17'h10000);
  endfunction

  function automatic bit addr_good(input logic [63:0] a);
    if (a[11:0] != 12'd0) return 1'b0;
    if (window_q < WIN_MIN) return 1'b0;
    return a <= (64'(window_q) - 64'd4096);
  endfunction

  function automatic bit room_for(input int need);
    return !batch_sealed && (int'(words_used) + need <= CAPACITY);
  endfunction

  // expected replies for one accepted request
  task automatic encode_request(input req_t r);
    logic [31:0] words [10];
    int          n;
    status_e     st;
    st = ST_OK;
    n  = 0;
    case (r.cmd)
      CMD_BEGIN: begin
        words_used   = '0;
        batch_sealed = 1'b0;
      end
      CMD_BLIT: begin
        if (!pitch_good(r.dst_pitch) || !pitch_good(r.src_pitch)) st = ST_PITCH;
        else if (!room_for(10)) st = ST_ROOM;
        else if (!rect_good(r.dst_x, r.dst_y, r.rect_w, r.rect_h) ||
                 !rect_good(r.src_x, r.src_y, r.rect_w, r.rect_h)) st = ST_RECT;
        else if (!addr_good(r.dst_addr) || !addr_good(r.src_addr)) st = ST_ADDR;
        else begin
          words[0] = COPY_HEADER;
          words[1] = ROP_SOURCE | COLOUR_DEPTH | {16'd0, r.dst_pitch[13:0], 2'b00};
          words[2] = {r.dst_y, r.dst_x};
          words[3] = {r.rect_h, r.rect_w};
          words[4] = r.dst_addr[31:0];
          words[5] = r.dst_addr[63:32];
          words[6] = {r.src_y, r.src_x};
          words[7] = {16'd0, r.src_pitch[13:0], 2'b00};
          words[8] = r.src_addr[31:0];
          words[9] = r.src_addr[63:32];
          n = 10;
        end
      end
      CMD_FILL: begin
        if (!room_for(7)) st = ST_ROOM;
        else if (!rect_good(r.dst_x, r.dst_y, r.rect_w, r.rect_h)) st = ST_RECT;
        else if (!pitch_good(r.dst_pitch)) st = ST_PITCH;
        else if (!addr_good(r.dst_addr)) st = ST_ADDR;
        else begin
          words[0] = FILL_HEADER;
          words[1] = COLOUR_DEPTH | ROP_PATTERN | {16'd0, r.dst_pitch[13:0], 2'b00};
          words[2] = r.dst_addr[31:0];
          words[3] = r.dst_addr[63:32];
          words[4] = r.color;
          words[5] = {r.dst_y, r.dst_x};
          words[6] = {r.rect_h, r.rect_w};
          n = 7;
        end
      end
      default: begin
        if (!room_for(1)) st = ST_ROOM;
        else begin
          words[0] = END_WORD;
          n = 1;
        end
      end
    endcase
    if (n == 0)
      reply_q.push_back('{word: 32'd0, index: 10'd0, valid: 1'b0, status: st, last: 1'b1});
    for (int k = 0; k < n; k++) begin
      reply_q.push_back('{word: words[k], index: words_used[9:0], valid: 1'b1,
                          status: ST_OK, last: (k == n - 1)});
      words_used++;
    end
    if (r.cmd == CMD_END && n == 1) batch_sealed = 1'b1;
  endtask

  // one request transfer on the slave side
  task automatic send_req(input req_t r);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    @(negedge clk_i);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pack_req(r);
    s_tuser  <= r.cmd;
    do @(posedge clk_i); while (!s_tready);
    encode_request(r);
  endtask

  // stop offering and let every outstanding reply arrive
  task automatic wait_replies();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] value);
    wait_replies();
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    window_q = value;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // request builders
  function automatic req_t plain_req(input cmd_e c);
    req_t r;
    r.cmd       = c;
    r.dst_addr  = 64'h0;
    r.dst_pitch = 16'd256;
    r.src_addr  = 64'h1000;
    r.src_pitch = 16'd256;
    r.src_x     = 16'd0;
    r.src_y     = 16'd0;
    r.dst_x     = 16'd0;
    r.dst_y     = 16'd0;
    r.rect_w    = 16'd16;
    r.rect_h    = 16'd16;
    r.color     = 32'h00FF_00FF;
    return r;
  endfunction

  function automatic req_t noise_req();
    req_t r;
    r.cmd       = cmd_e'($urandom_range(0, 3));
    r.dst_addr  = {$urandom(), $urandom()};
    r.dst_pitch = 16'($urandom());
    r.src_addr  = {$urandom(), $urandom()};
    r.src_pitch = 16'($urandom());
    r.src_x     = 16'($urandom());
    r.src_y     = 16'($urandom());
    r.dst_x     = 16'($urandom());
    r.dst_y     = 16'($urandom());
    r.rect_w    = 16'($urandom());
    r.rect_h    = 16'($urandom());
    r.color     = $urandom();
    return r;
  endfunction

  function automatic logic [15:0] good_pitch();
    case ($urandom_range(0, 4))
      0:       return 16'd16383;
      1:       return 16'($urandom_range(1, 16383));
      default: return 16'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic logic [15:0] bad_pitch();
    if ($urandom_range(0, 1)) return 16'd0;
    return 16'($urandom_range(16384, 65535));
  endfunction

  function automatic logic [15:0] good_size();
    case ($urandom_range(0, 7))
      0:       return 16'hFFFF;
      1:       return 16'($urandom_range(1, 65535));
      default: return 16'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic logic [15:0] good_pos(input logic [15:0] size);
    if ($urandom_range(0, 7) == 0) return 16'(65536 - int'(size));
    return 16'($urandom_range(0, 65536 - int'(size)));
  endfunction

  function automatic logic [63:0] good_page();
    logic [63:0] pages;
    logic [63:0] idx;
    pages = 64'(window_q) >> 12;
    case ($urandom_range(0, 5))
      0:       idx = 64'd0;
      1:       idx = pages - 64'd1;
      default: idx = {$urandom(), $urandom()} % pages;
    endcase
    return idx << 12;
  endfunction

  function automatic req_t good_req(input cmd_e c);
    req_t r;
    r     = noise_req();
    r.cmd = c;
    if (c == CMD_BLIT || c == CMD_FILL) begin
      r.dst_pitch = good_pitch();
      r.src_pitch = good_pitch();
      r.rect_w    = good_size();
      r.rect_h    = good_size();
      r.dst_x     = good_pos(r.rect_w);
      r.src_x     = good_pos(r.rect_w);
      r.dst_y     = good_pos(r.rect_h);
      r.src_y     = good_pos(r.rect_h);
      r.dst_addr  = good_page();
      r.src_addr  = good_page();
    end
    return r;
  endfunction

  // spoil one field (or the width and x pair) of an otherwise good request
  function automatic req_t broken_req(input req_t r);
    case ($urandom_range(0, 6))
      0: r.dst_pitch = bad_pitch();
      1: r.src_pitch = bad_pitch();
      2: r.rect_w = 16'd0;
      3: r.rect_h = 16'd0;
      4: begin
        r.rect_w = 16'hFFFF;
        r.dst_x  = 16'($urandom_range(2, 65535));
      end
      5: r.dst_addr = r.dst_addr | 64'($urandom_range(1, 4095));
      default: r.src_addr = ((64'(window_q) + 64'hFFF) & ~64'hFFF) +
                            (64'($urandom_range(0, 255)) << 12);
    endcase
    return r;
  endfunction

  function automatic req_t random_req();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 6) return good_req(CMD_BEGIN);
    if (pick < 10) return good_req(CMD_END);
    if (pick < 50) return good_req(CMD_BLIT);
    if (pick < 78) return good_req(CMD_FILL);
    if (pick < 90) return broken_req(good_req(pick[0] ? CMD_BLIT : CMD_FILL));
    return noise_req();
  endfunction

  function automatic logic [WIN_W-1:0] random_window();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    if ($urandom_range(0, 1))
      return WIN_W'(64'd4096 + (r % 64'h100_0000));
    return WIN_W'(64'd4096 + (r % (64'(WIN_MAX) - 64'd4095)));
  endfunction

  // master side: a fresh stall before each transfer, or a long hold when asked
  initial begin : result_sink
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, rx_stall_max);
      if (rx_hold_len > 0) begin
        stall       = rx_hold_len;
        rx_hold_len = 0;
      end
      @(negedge clk_i);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] exp_v,
                                 input logic [63:0] act_v);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
    error_count++;
  endtask

  // compare each reply transfer with the oldest expectation
  always @(posedge clk_i) begin
    reply_t exp_r;
    if (rst_ni && m_tvalid && m_tready) begin
      if (reply_q.size() == 0) begin
        $display("%0t: unexpected reply, expected none, actual word %0h status %0d",
                 $time, m_tdata[31:0], m_tuser[3:1]);
        error_count++;
      end else begin
        exp_r = reply_q.pop_front();
        if (m_tdata[31:0] !== exp_r.word) report_mismatch("word", exp_r.word, m_tdata[31:0]);
        if (m_tdata[41:32] !== exp_r.index)
          report_mismatch("word_index", exp_r.index, m_tdata[41:32]);
        if (m_tuser[0] !== exp_r.valid) report_mismatch("word_valid", exp_r.valid, m_tuser[0]);
        if (m_tuser[3:1] !== exp_r.status)
          report_mismatch("status", exp_r.status, m_tuser[3:1]);
        if (m_tlast !== exp_r.last) report_mismatch("last", exp_r.last, m_tlast);
      end
    end
  end

  // good blit, copy, fill and end, then requests against a sealed batch
  task automatic test_basic_requests();
    req_t r;
    send_req(plain_req(CMD_BEGIN));
    r = plain_req(CMD_BLIT);
    r.dst_pitch = 16'd1;
    r.src_pitch = 16'd16383;
    r.src_addr  = 64'h7F_F000;
    r.dst_x = 16'd1;
    r.rect_w = 16'hFFFF;
    r.src_y = 16'd1;
    r.rect_h = 16'hFFFF;
    send_req(r);
    // copy: same corners on both sides
    r = plain_req(CMD_BLIT);
    r.dst_addr = 64'h5000;
    r.src_addr = 64'h5000;
    r.dst_x = 16'd100;
    r.src_x = 16'd100;
    r.dst_y = 16'd200;
    r.src_y = 16'd200;
    r.rect_w = 16'd1;
    r.rect_h = 16'd1;
    send_req(r);
    r = plain_req(CMD_FILL);
    r.color = 32'hFFFF_FFFF;
    r.dst_addr = 64'h7F_F000;
    r.dst_pitch = 16'd16383;
    r.dst_x = 16'hFFFF;
    r.dst_y = 16'hFFFF;
    r.rect_w = 16'd1;
    r.rect_h = 16'd1;
    send_req(r);
    r = plain_req(CMD_FILL);
    r.color = 32'd0;
    r.dst_pitch = 16'd1;
    r.src_addr = '1;
    r.src_pitch = '1;
    send_req(r);
    send_req(plain_req(CMD_END));
    send_req(plain_req(CMD_BLIT));
    send_req(plain_req(CMD_FILL));
    send_req(plain_req(CMD_END));
    send_req(plain_req(CMD_BEGIN));
  endtask

  // each rejection code and the order in which checks apply
  task automatic test_rejections();
    req_t r;
    r = plain_req(CMD_BLIT); r.dst_pitch = 16'd0;      send_req(r);
    r = plain_req(CMD_BLIT); r.dst_pitch = 16'd16384;  send_req(r);
    r = plain_req(CMD_BLIT); r.src_pitch = 16'd0;      send_req(r);
    r = plain_req(CMD_BLIT); r.src_pitch = 16'hFFFF;   send_req(r);
    r = plain_req(CMD_BLIT); r.rect_w = 16'd0;         send_req(r);
    r = plain_req(CMD_BLIT); r.rect_h = 16'd0;         send_req(r);
    r = plain_req(CMD_BLIT); r.dst_x = 16'hFFFF; r.rect_w = 16'd2; send_req(r);
    r = plain_req(CMD_BLIT); r.src_y = 16'hFFFF; r.rect_h = 16'd2; send_req(r);
    r = plain_req(CMD_BLIT); r.dst_addr = 64'h800;     send_req(r);
    r = plain_req(CMD_BLIT); r.src_addr = 64'h80_0000; send_req(r);
    r = plain_req(CMD_BLIT); r.dst_addr = 64'hFFFF_FFFF_FFFF_F000; send_req(r);
    // fill with bad rectangle and bad pitch reports the rectangle
    r = plain_req(CMD_FILL); r.rect_w = 16'd0; r.dst_pitch = 16'd0; send_req(r);
    // fill with bad pitch and unaligned address reports the pitch
    r = plain_req(CMD_FILL); r.dst_pitch = 16'd0; r.dst_addr = 64'h10; send_req(r);
    r = plain_req(CMD_FILL); r.dst_addr = 64'h80_1000; send_req(r);
    // pitch is checked ahead of the sealed batch for a blit, not for a fill
    send_req(plain_req(CMD_END));
    r = plain_req(CMD_BLIT); r.dst_pitch = 16'd0; send_req(r);
    r = plain_req(CMD_FILL); r.rect_w = 16'd0; send_req(r);
    send_req(plain_req(CMD_BEGIN));
  endtask

  // smallest and largest window
  task automatic test_window_limits();
    req_t r;
    write_window(WIN_MIN);
    send_req(plain_req(CMD_BEGIN));
    send_req(plain_req(CMD_FILL));
    r = plain_req(CMD_BLIT); r.src_addr = 64'h0; send_req(r);
    r = plain_req(CMD_FILL); r.dst_addr = 64'h1000; send_req(r);
    write_window(WIN_MAX);
    r = plain_req(CMD_FILL); r.dst_addr = 64'h0000_FFFF_FFFF_F000; send_req(r);
    r = plain_req(CMD_BLIT); r.src_addr = 64'h0001_0000_0000_0000; send_req(r);
    write_window(WIN_BOOT);
  endtask

  // fill the batch to its last word, then run into the capacity
  task automatic test_full_batch();
    int blits_left;
    int fills_left;
    write_window(random_window());
    tx_gap_max   = 0;
    rx_stall_max = 0;
    send_req(good_req(CMD_BEGIN));
    blits_left = 96;
    fills_left = 9;
    while (blits_left + fills_left > 0) begin
      if (blits_left + fills_left == 52) begin
        tx_gap_max   = 18;
        rx_stall_max = 18;
      end
      if ($urandom_range(1, blits_left + fills_left) <= blits_left) begin
        send_req(good_req(CMD_BLIT));
        blits_left--;
      end else begin
        send_req(good_req(CMD_FILL));
        fills_left--;
      end
    end
    send_req(good_req(CMD_FILL));
    send_req(good_req(CMD_BLIT));
    send_req(good_req(CMD_END));
    send_req(good_req(CMD_END));
    send_req(good_req(CMD_BEGIN));
  endtask

  // master side held off while requests keep coming
  task automatic test_output_stall();
    wait_replies();
    tx_gap_max  = 0;
    rx_hold_len = 150;
    send_req(good_req(CMD_BEGIN));
    repeat (12) send_req(good_req(CMD_BLIT));
    wait_replies();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_window(random_window());
        1: write_window(WIN_MAX);
        2: write_window(random_window());
        default: write_window(WIN_MIN);
      endcase
      tx_gap_max   = phase[0] ? 18 : 0;
      rx_stall_max = phase[1] ? 0 : 18;
      send_req(good_req(CMD_BEGIN));
      repeat (32) send_req(random_req());
    end
  endtask

  initial begin
    window_q     = WIN_BOOT;
    words_used   = '0;
    batch_sealed = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_basic_requests();
    test_rejections();
    test_window_limits();
    test_full_batch();
    test_output_stall();
    test_random_traffic();

    wait_replies();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
